### sv/sbms_pkg.sv
// ============================================================================
// Softmax bandit mode select package
// Field types and fixed constants shared by the channels and the datapath.
// ============================================================================
`default_nettype none

package sbms_pkg;

    typedef logic [31:0] conflict_t;
    typedef logic [31:0] glue_t;
    typedef logic [47:0] low_glue_t;
    typedef logic [15:0] fraction_t;
    typedef logic [1:0]  mode_count_t;
    typedef logic [7:0]  stall_t;

    // A glue average below 1.0 in Q16.16 counts as 1.0.
    localparam glue_t GLUE_UNIT = 32'h0001_0000;

    // Partial remainder of 2^(F+16) before the first quotient bit at weight 2^F.
    localparam logic [31:0] DIV_REM_SEED = 32'h0000_8000;

    localparam stall_t STALL_LIMIT = 8'd6;
    localparam stall_t STALL_MAX   = 8'd255;

    localparam mode_count_t MODE_COUNT_RESET = 2'd2;

    // Fraction bits of the random input.
    localparam int RND_BITS = 16;

endpackage

`default_nettype wire

### sv/sbms_if.sv
// ============================================================================
// Softmax bandit mode select channels
// Valid/ready channels for restart events, decisions and the config write.
// ============================================================================
`default_nettype none

interface sbms_in_if
    import sbms_pkg::*;
;
    logic      valid;
    logic      ready;
    conflict_t conflict_count;
    glue_t     glue_average;
    low_glue_t low_glue_total;
    fraction_t random_fraction;
    logic      active_mode;

    modport source (
        output valid,
        output conflict_count,
        output glue_average,
        output low_glue_total,
        output random_fraction,
        output active_mode,
        input  ready
    );

    modport sink (
        input  valid,
        input  conflict_count,
        input  glue_average,
        input  low_glue_total,
        input  random_fraction,
        input  active_mode,
        output ready
    );
endinterface

interface sbms_out_if;
    logic valid;
    logic ready;
    logic chosen_mode;
    logic stagnating;

    modport source (
        output valid,
        output chosen_mode,
        output stagnating,
        input  ready
    );

    modport sink (
        input  valid,
        input  chosen_mode,
        input  stagnating,
        output ready
    );
endinterface

interface sbms_cfg_if
    import sbms_pkg::*;
;
    logic        valid;
    logic        ready;
    mode_count_t mode_count;

    modport source (
        output valid,
        output mode_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  mode_count,
        output ready
    );
endinterface

`default_nettype wire

### sv/sbms_divider.sv
// ============================================================================
// Reward divider
// Restoring divider that forms floor(2^(F+16) / divisor), one quotient bit
// per cycle, for a divisor of at least 2^16.
// ============================================================================
`default_nettype none

module sbms_divider
    import sbms_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire glue_t                    divisor,
    output logic                          done,
    output logic [FRACTION_BITS:0]        quotient
);

    localparam int CNT_W = $clog2(FRACTION_BITS + 2);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [31:0]            rem_reg;
    glue_t                  div_reg;
    logic [FRACTION_BITS:0] quot_reg;

    logic [32:0] trial;
    logic        fits;
    logic [31:0] rem_next;

    // The remainder always stays below the divisor, so doubling it fits in
    // 33 bits and the sign of the trial difference tells whether it fits.
    always_comb
    begin
        trial    = {rem_reg, 1'b0} - {1'b0, div_reg};
        fits     = ~trial[32];
        rem_next = fits ? trial[31:0] : {rem_reg[30:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRACTION_BITS);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DIV_REM_SEED;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[FRACTION_BITS-1:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

### sv/softmax_bandit_mode_select.sv
// ============================================================================
// Softmax bandit mode select
// Per restart event: reward from glue, EMA update, stagnation penalty and a
// two-way softmax draw of the next heuristic mode.
// ============================================================================
//
//  Channel   Role   Carries
//  --------  -----  ---------------------------------------------------------
//  restart   sink   conflict_count, glue_average, low_glue_total,
//                   random_fraction, active_mode
//  decision  source chosen_mode, stagnating
//  cfg       sink   mode_count (always ready)
//
//  After its restart transfer an event runs the serial reward divider, the
//  EMA update, the priorities, the table index and lookup and the draw, and
//  then offers its result. The first event skips the EMA update, a zero
//  conflict count skips the divider, and fewer than two modes in use skip
//  the table index, lookup and draw. restart is ready again in the cycle
//  the result is offered, so the block takes no new event while one is in
//  work. The EMA products, the table index and the draw share one multiplier.
//  Reset clears all averages, the stall counter and the seeded flag, and sets
//  mode_count to 2. A result waiting on decision does not block the next
//  restart transfer; a second result waits until the first is taken, and
//  restart is not ready meanwhile.
//
`default_nettype none

module softmax_bandit_mode_select
    import sbms_pkg::*;
#(
    parameter int FRACTION_BITS   = 16,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sbms_in_if.sink    restart,
    sbms_out_if.source decision,
    sbms_cfg_if.sink   cfg
);

    localparam int F       = FRACTION_BITS;
    localparam int EMA_W   = F + 2;
    localparam int R_W     = F + 1;
    localparam int ROM_W   = F + 1;
    localparam int MUL_A_W = (F > RND_BITS) ? F : RND_BITS;
    localparam int MUL_B_W = F + 6;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 2 * F + 4;
    localparam int BASE_W  = F + 5;
    localparam int PRI_W   = F + 6;
    localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);

    localparam longint ONE_VAL        = 64'd1 << F;
    localparam longint QUICK_GAIN_VAL = (3 * ONE_VAL + 5) / 10;
    localparam longint LAZY_GAIN_VAL  = (ONE_VAL + 10) / 20;

    localparam logic [MUL_A_W-1:0] A_FAST     = MUL_A_W'(QUICK_GAIN_VAL);
    localparam logic [MUL_A_W-1:0] KEEP_FAST  = MUL_A_W'(ONE_VAL - QUICK_GAIN_VAL);
    localparam logic [MUL_A_W-1:0] A_SLOW     = MUL_A_W'(LAZY_GAIN_VAL);
    localparam logic [MUL_A_W-1:0] KEEP_SLOW  = MUL_A_W'(ONE_VAL - LAZY_GAIN_VAL);
    localparam logic [MUL_A_W-1:0] DEPTH_MUL  = MUL_A_W'(EXP_TABLE_DEPTH);
    localparam logic [ACC_W-1:0]   ACC_HALF   = ACC_W'(ONE_VAL >> 1);
    localparam logic [ROM_W-1:0]   WEIGHT_ONE = ROM_W'(ONE_VAL);
    localparam logic [IDX_W-1:0]   IDX_MAX    = IDX_W'(EXP_TABLE_DEPTH - 1);
    localparam logic [PROD_W-1:0]  IDX_LIMIT  = PROD_W'(EXP_TABLE_DEPTH - 1);

    typedef logic [ROM_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

    // Restoring division used only while the table is built.
    function automatic logic [63:0] quotient64(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-x) for x = 2i/DEPTH in Q.F, from a 30-term Q.30 Taylor sum of exp(x).
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            x    = quotient64(64'(i) << 31, 64'(EXP_TABLE_DEPTH));
            term = 64'd1 << 30;
            sum  = term;
            for (int n = 1; n < 30; n++)
            begin
                term = quotient64((term * x) >> 30, 64'(n));
                sum  = sum + term;
            end
            rom[i] = ROM_W'(quotient64((64'd1 << (30 + F)) + (sum >> 1), sum));
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_MF1,
        S_MF2,
        S_MS1,
        S_MS2,
        S_MEND,
        S_PRIO,
        S_DIFF,
        S_IDX,
        S_CLAMP,
        S_ROM,
        S_RMUL,
        S_DECIDE
    } state_t;

    // Control and architectural state.
    state_t             state_reg;
    logic               out_valid_reg;
    logic               chosen_reg;
    logic               stag_out_reg;
    logic               seeded_reg;
    stall_t             stall_reg;
    low_glue_t          prev_low_reg;
    logic [EMA_W-1:0]   fast_reg [2];
    logic [EMA_W-1:0]   slow_reg [2];
    mode_count_t        mode_count_reg;

    // Per-event datapath registers.
    logic               zero_reg;
    logic               act_reg;
    fraction_t          rnd_reg;
    logic               stag_reg;
    logic [R_W-1:0]     r_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic signed [PRI_W-1:0] p_reg [2];
    logic [MUL_B_W-1:0] d_reg;
    logic               ge_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [ROM_W-1:0]   t_reg;

    logic               in_accept;
    stall_t             stall_next;
    glue_t              glue_clamped;
    logic               div_start;
    logic               div_done;
    logic [R_W-1:0]     div_quot;
    logic [R_W-1:0]     r_next;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [ACC_W-1:0]   ema_sum;
    logic [EMA_W-1:0]   ema_new;
    logic signed [PRI_W-1:0] p_next [2];
    logic [BASE_W-1:0]  base [2];
    logic [PRI_W:0]     diff;
    logic [PRI_W:0]     diff_neg;
    logic [MUL_B_W-1:0] d_next;
    logic [PROD_W-1:0]  idx_wide;
    logic [IDX_W-1:0]   idx_next;
    logic [ROM_W:0]     weight_sum;
    logic [ROM_W-1:0]   e0;
    logic               chosen_next;

    assign in_accept     = restart.valid && restart.ready;
    assign restart.ready = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;

    assign decision.valid       = out_valid_reg;
    assign decision.chosen_mode = chosen_reg;
    assign decision.stagnating  = stag_out_reg;

    // The first event still counts as a stall, since the new total is only
    // compared with the recorded one once the averages are seeded.
    always_comb
    begin
        if (seeded_reg && (restart.low_glue_total > prev_low_reg))
        begin
            stall_next = '0;
        end
        else if (stall_reg == STALL_MAX)
        begin
            stall_next = STALL_MAX;
        end
        else
        begin
            stall_next = stall_reg + 1'b1;
        end
    end

    assign glue_clamped = (restart.glue_average < GLUE_UNIT) ? GLUE_UNIT
                                                             : restart.glue_average;
    assign div_start    = in_accept && (restart.conflict_count != '0);

    sbms_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (glue_clamped),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign r_next = zero_reg ? '0 : div_quot;

    // Shared multiplier operand selection.
    always_comb
    begin
        weight_sum = {1'b0, WEIGHT_ONE} + {1'b0, t_reg};
        unique case (state_reg)
            S_MF1:
            begin
                mul_a = A_FAST;
                mul_b = MUL_B_W'(r_reg);
            end
            S_MF2:
            begin
                mul_a = KEEP_FAST;
                mul_b = MUL_B_W'(fast_reg[act_reg]);
            end
            S_MS1:
            begin
                mul_a = A_SLOW;
                mul_b = MUL_B_W'(r_reg);
            end
            S_MS2:
            begin
                mul_a = KEEP_SLOW;
                mul_b = MUL_B_W'(slow_reg[act_reg]);
            end
            S_IDX:
            begin
                mul_a = DEPTH_MUL;
                mul_b = d_reg;
            end
            S_RMUL:
            begin
                mul_a = MUL_A_W'(rnd_reg);
                mul_b = MUL_B_W'(weight_sum);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign ema_sum = acc_reg + ACC_W'(prod_reg);
    assign ema_new = EMA_W'(ema_sum >> F);

    // Priority in units of 2^-F: 2*(3*fast - slow), halved for the
    // active mode under the stagnation penalty.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            base[i] = ({3'b000, fast_reg[i]} << 1) + {3'b000, fast_reg[i]}
                      - {3'b000, slow_reg[i]};
            if (stag_reg && (act_reg == 1'(i)))
            begin
                p_next[i] = $signed({base[i][BASE_W-1], base[i]});
            end
            else
            begin
                p_next[i] = $signed({base[i], 1'b0});
            end
        end
    end

    always_comb
    begin
        diff     = {p_reg[0][PRI_W-1], p_reg[0]} - {p_reg[1][PRI_W-1], p_reg[1]};
        diff_neg = ~diff + 1'b1;
        d_next   = diff[PRI_W] ? diff_neg[PRI_W-1:0] : diff[PRI_W-1:0];
    end

    always_comb
    begin
        idx_wide = prod_reg >> (F + 3);
        idx_next = (idx_wide > IDX_LIMIT) ? IDX_MAX : idx_wide[IDX_W-1:0];
    end

    // The larger priority weighs one, the other the table value.
    assign e0          = ge_reg ? WEIGHT_ONE : t_reg;
    assign chosen_next = mode_count_reg[1]
                         && !(prod_reg < (PROD_W'(e0) << RND_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            chosen_reg     <= 1'b0;
            stag_out_reg   <= 1'b0;
            seeded_reg     <= 1'b0;
            stall_reg      <= '0;
            prev_low_reg   <= '0;
            fast_reg[0]    <= '0;
            fast_reg[1]    <= '0;
            slow_reg[0]    <= '0;
            slow_reg[1]    <= '0;
            mode_count_reg <= MODE_COUNT_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                mode_count_reg <= cfg.mode_count;
            end
            // In S_DECIDE the output valid is handled by the state itself.
            if (out_valid_reg && decision.ready && (state_reg != S_DECIDE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        stall_reg    <= stall_next;
                        prev_low_reg <= restart.low_glue_total;
                        state_reg    <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (zero_reg || div_done)
                    begin
                        if (seeded_reg)
                        begin
                            state_reg <= S_MF1;
                        end
                        else
                        begin
                            fast_reg[0] <= EMA_W'(r_next);
                            fast_reg[1] <= EMA_W'(r_next);
                            slow_reg[0] <= EMA_W'(r_next);
                            slow_reg[1] <= EMA_W'(r_next);
                            seeded_reg  <= 1'b1;
                            state_reg   <= S_PRIO;
                        end
                    end
                end
                S_MF1:
                begin
                    state_reg <= S_MF2;
                end
                S_MF2:
                begin
                    state_reg <= S_MS1;
                end
                S_MS1:
                begin
                    fast_reg[act_reg] <= ema_new;
                    state_reg         <= S_MS2;
                end
                S_MS2:
                begin
                    state_reg <= S_MEND;
                end
                S_MEND:
                begin
                    slow_reg[act_reg] <= ema_new;
                    state_reg         <= S_PRIO;
                end
                S_PRIO:
                begin
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    state_reg <= mode_count_reg[1] ? S_IDX : S_DECIDE;
                end
                S_IDX:
                begin
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    state_reg <= S_ROM;
                end
                S_ROM:
                begin
                    state_reg <= S_RMUL;
                end
                S_RMUL:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (!out_valid_reg || decision.ready)
                    begin
                        chosen_reg    <= chosen_next;
                        stag_out_reg  <= stag_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        // The draw product must stay put while the result waits in S_DECIDE.
        if (state_reg != S_DECIDE)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end

        if (in_accept)
        begin
            zero_reg <= (restart.conflict_count == '0);
            act_reg  <= restart.active_mode;
            rnd_reg  <= restart.random_fraction;
            stag_reg <= (stall_next > STALL_LIMIT);
        end

        case (state_reg)
            S_DIV:
            begin
                r_reg <= r_next;
            end
            S_MF1:
            begin
                acc_reg <= ACC_HALF;
            end
            S_MF2:
            begin
                acc_reg <= ema_sum;
            end
            S_MS1:
            begin
                acc_reg <= ACC_HALF;
            end
            S_MS2:
            begin
                acc_reg <= ema_sum;
            end
            S_PRIO:
            begin
                p_reg[0] <= p_next[0];
                p_reg[1] <= p_next[1];
            end
            S_DIFF:
            begin
                d_reg  <= d_next;
                ge_reg <= ~diff[PRI_W];
            end
            S_CLAMP:
            begin
                idx_reg <= idx_next;
            end
            S_ROM:
            begin
                t_reg <= EXP_ROM[idx_reg];
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### dv/sbms_decision_checker.sv
// ============================================================================
// Softmax bandit mode select decision checker
// Watches the restart, decision and config channels, predicts each decision
// from its own copy of the averages and stall counter, and compares in order.
// ============================================================================
`timescale 1ns / 1ps

module sbms_decision_checker
    import sbms_pkg::*;
#(
    parameter int FRACTION_BITS   = 16,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    sbms_in_if   restart,
    sbms_out_if  decision,
    sbms_cfg_if  cfg,
    output int   mismatches,
    output int   outstanding
);

    localparam longint unsigned ONE        = 64'd1 << FRACTION_BITS;
    localparam longint unsigned QUICK_GAIN = (3 * ONE + 5) / 10;
    localparam longint unsigned LAZY_GAIN  = (ONE + 10) / 20;

    typedef struct packed {
        logic chosen_mode;
        logic stagnating;
    } decision_t;

    longint unsigned exp_weight [EXP_TABLE_DEPTH];
    longint unsigned quick_avg [2];
    longint unsigned lazy_avg [2];
    low_glue_t       last_low_glue;
    stall_t          stall_run;
    logic            seeded;
    mode_count_t     mode_count;
    decision_t       expected_decisions [$];
    int              error_count = 0;

    // exp(x) for x in Q.30, by a truncated Taylor series.
    function automatic longint unsigned exp_q30(input longint unsigned x);
        longint unsigned term;
        longint unsigned sum;
        longint unsigned n;
        term = 64'd1 << 30;
        sum  = term;
        for (n = 1; n < 30; n++)
        begin
            term = ((term * x) >> 30) / n;
            sum += term;
        end
        return sum;
    endfunction

    function automatic longint unsigned ema_step(input longint unsigned old,
                                                 input longint unsigned reward,
                                                 input longint unsigned alpha);
        return (alpha * reward + (ONE - alpha) * old + ONE / 2) >> FRACTION_BITS;
    endfunction

    function automatic decision_t predict_decision(input conflict_t conflicts,
                                                   input glue_t     glue,
                                                   input low_glue_t low_glue,
                                                   input fraction_t rnd,
                                                   input logic      act);
        longint unsigned reward;
        longint unsigned divisor;
        longint unsigned spread;
        longint unsigned idx;
        longint unsigned e0;
        longint unsigned e1;
        longint unsigned rnd_wide;
        longint          prio [2];
        decision_t       result;

        reward = 0;
        if (conflicts != 0)
        begin
            divisor = (glue < GLUE_UNIT) ? GLUE_UNIT : glue;
            reward  = (64'd1 << (FRACTION_BITS + 16)) / divisor;
        end

        if (!seeded)
        begin
            quick_avg[0]  = reward;
            quick_avg[1]  = reward;
            lazy_avg[0]   = reward;
            lazy_avg[1]   = reward;
            last_low_glue = low_glue;
            seeded        = 1'b1;
        end
        else
        begin
            quick_avg[act] = ema_step(quick_avg[act], reward, QUICK_GAIN);
            lazy_avg[act]  = ema_step(lazy_avg[act], reward, LAZY_GAIN);
        end

        if (low_glue > last_low_glue)
            stall_run = '0;
        else if (stall_run < STALL_MAX)
            stall_run++;
        last_low_glue = low_glue;

        result.stagnating = (stall_run > STALL_LIMIT);
        prio[0] = 2 * (3 * longint'(quick_avg[0]) - longint'(lazy_avg[0]));
        prio[1] = 2 * (3 * longint'(quick_avg[1]) - longint'(lazy_avg[1]));
        if (result.stagnating)
            prio[act] = prio[act] / 2;

        result.chosen_mode = 1'b0;
        if (mode_count >= 2'd2)
        begin
            spread = (prio[0] >= prio[1]) ? prio[0] - prio[1] : prio[1] - prio[0];
            idx    = (spread * EXP_TABLE_DEPTH) >> (FRACTION_BITS + 3);
            if (idx > EXP_TABLE_DEPTH - 1)
                idx = EXP_TABLE_DEPTH - 1;
            // The higher priority weighs one, the other exp(-difference).
            if (prio[0] >= prio[1])
            begin
                e0 = ONE;
                e1 = exp_weight[idx];
            end
            else
            begin
                e0 = exp_weight[idx];
                e1 = ONE;
            end
            rnd_wide = rnd;
            result.chosen_mode = !(rnd_wide * (e0 + e1) < (e0 << RND_BITS));
        end
        return result;
    endfunction

    initial
    begin : build_exp_table
        longint unsigned i;
        longint unsigned x;
        longint unsigned e;
        for (i = 0; i < EXP_TABLE_DEPTH; i++)
        begin
            x = (i << 31) / EXP_TABLE_DEPTH;
            e = exp_q30(x);
            exp_weight[i] = ((64'd1 << (30 + FRACTION_BITS)) + e / 2) / e;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : track
        decision_t got;
        decision_t want;
        if (!rst_n)
        begin
            quick_avg[0]  = 0;
            quick_avg[1]  = 0;
            lazy_avg[0]   = 0;
            lazy_avg[1]   = 0;
            last_low_glue = '0;
            stall_run     = '0;
            seeded        = 1'b0;
            mode_count    = MODE_COUNT_RESET;
            expected_decisions.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                mode_count = cfg.mode_count;

            if (restart.valid && restart.ready)
                expected_decisions.push_back(predict_decision(restart.conflict_count,
                                                              restart.glue_average,
                                                              restart.low_glue_total,
                                                              restart.random_fraction,
                                                              restart.active_mode));

            if (decision.valid && decision.ready)
            begin
                got.chosen_mode = decision.chosen_mode;
                got.stagnating  = decision.stagnating;
                if (expected_decisions.size() == 0)
                begin
                    $display("%0t: decision transfer with no event pending: %s %b %s %b",
                             $time, "chosen_mode", got.chosen_mode,
                             "stagnating", got.stagnating);
                    error_count++;
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    if (got.chosen_mode !== want.chosen_mode)
                    begin
                        $display("%0t: chosen_mode expected %b actual %b",
                                 $time, want.chosen_mode, got.chosen_mode);
                        error_count++;
                    end
                    if (got.stagnating !== want.stagnating)
                    begin
                        $display("%0t: stagnating expected %b actual %b",
                                 $time, want.stagnating, got.stagnating);
                        error_count++;
                    end
                end
            end
        end
        mismatches  <= error_count;
        outstanding <= expected_decisions.size();
    end

endmodule

### dv/softmax_bandit_mode_select_test.sv
// ============================================================================
// Softmax bandit mode select testbench
// Drives restart events and mode_count writes with random idling on both
// channels, including a long decision stall, and reports the checker verdict.
// ============================================================================
`timescale 1ns / 1ps

module softmax_bandit_mode_select_test;
    import sbms_pkg::*;

    localparam int FRACTION_BITS   = 16;
    localparam int EXP_TABLE_DEPTH = 256;
    localparam int DRAIN_CYCLES    = FRACTION_BITS + 24;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic      clk;
    logic      rst_n;
    int        mismatches;
    int        outstanding;
    logic      steady;
    logic      long_hold_req;
    logic      favored_mode;
    low_glue_t low_glue_now;

    sbms_in_if  restart_ch ();
    sbms_out_if decision_ch ();
    sbms_cfg_if cfg_ch ();

    softmax_bandit_mode_select #(
        .FRACTION_BITS   (FRACTION_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart_ch),
        .decision (decision_ch),
        .cfg      (cfg_ch)
    );

    sbms_decision_checker #(
        .FRACTION_BITS   (FRACTION_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) decision_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart_ch),
        .decision    (decision_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly back to back, sometimes a few cycles, rarely a long pause.
    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_event(input conflict_t conflicts, input glue_t glue,
                              input low_glue_t low_glue, input fraction_t rnd,
                              input logic act);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            restart_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        restart_ch.valid           <= 1'b1;
        restart_ch.conflict_count  <= conflicts;
        restart_ch.glue_average    <= glue;
        restart_ch.low_glue_total  <= low_glue;
        restart_ch.random_fraction <= rnd;
        restart_ch.active_mode     <= act;
        @(posedge clk);
        while (!restart_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_random_event(input logic keep_low);
        conflict_t conflicts;
        glue_t     glue;
        fraction_t rnd;
        logic      act;
        int        roll;

        act  = $urandom_range(0, 1);
        roll = $urandom_range(0, 99);
        if (roll < 12)
            conflicts = '0;
        else if (roll < 20)
            conflicts = '1;
        else if (roll < 60)
            conflicts = $urandom_range(1, 5000);
        else
            conflicts = $urandom;

        // The favored mode mostly sees low glue and so earns a high reward,
        // which pulls the two priorities apart.
        roll = $urandom_range(0, 99);
        if (roll < 10)
            glue = $urandom_range(0, 32'h0000_FFFF);
        else if (roll < 15)
            glue = '1;
        else if (roll < 30)
            glue = $urandom;
        else if (act == favored_mode)
            glue = $urandom_range(32'h0001_0000, 32'h0002_0000);
        else
            glue = $urandom_range(32'h0004_0000, 32'h0040_0000);

        if (!keep_low)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
                low_glue_now = low_glue_now + $urandom_range(1, 200);
            else if (roll >= 90)
                low_glue_now = {16'($urandom), 32'($urandom)};
        end

        roll = $urandom_range(0, 99);
        if (roll < 5)
            rnd = '0;
        else if (roll < 10)
            rnd = '1;
        else
            rnd = $urandom_range(0, 16'hFFFF);

        send_event(conflicts, glue, low_glue_now, rnd, act);
    endtask

    task automatic run_random(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 79) == 0)
                favored_mode = !favored_mode;
            send_random_event(1'b0);
        end
    endtask

    // Lets every pending decision arrive and the datapath go quiet.
    task automatic drain();
        restart_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode_count(input mode_count_t value);
        drain();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.mode_count <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        decision_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                decision_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                decision_ch.ready <= 1'b1;
                hold_left = pick_gap();
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((restart_ch.valid && restart_ch.ready) ||
                (decision_ch.valid && decision_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        rst_n                       = 1'b0;
        steady                      = 1'b0;
        long_hold_req               = 1'b0;
        favored_mode                = 1'b0;
        low_glue_now                = '0;
        restart_ch.valid           <= 1'b0;
        restart_ch.conflict_count  <= '0;
        restart_ch.glue_average    <= '0;
        restart_ch.low_glue_total  <= '0;
        restart_ch.random_fraction <= '0;
        restart_ch.active_mode     <= 1'b0;
        cfg_ch.valid               <= 1'b0;
        cfg_ch.mode_count          <= MODE_COUNT_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // The first event has glue below 1.0, so every average is seeded
        // with a full reward; all priorities tie.
        send_event(32'd1, 32'd0, 48'd5, 16'h0000, 1'b0);
        send_event('1, '1, 48'd6, 16'hFFFF, 1'b1);
        send_event('0, 32'h0000_8000, 48'd6, 16'h8000, 1'b0);
        send_event(32'd7, GLUE_UNIT, 48'd6, 16'h0001, 1'b1);
        // The low-glue count stands still, so the stall penalty kicks in.
        for (k = 0; k < 8; k++)
            send_event(32'd100, GLUE_UNIT + 32'(k) * 32'h4000, 48'd6,
                       (k % 2 == 1) ? 16'hFFFF : 16'h0000, (k % 2 == 1));
        send_event(32'd50, 32'h0003_0000, 48'd7, 16'h4000, 1'b0);
        send_event(32'd50, 32'h0002_0000, 48'hFFFF_FFFF_FFFF, 16'hC000, 1'b1);
        send_event(32'd50, 32'h0002_0000, 48'd0, 16'h2000, 1'b0);

        write_mode_count(2'd1);
        run_random(150);
        write_mode_count(2'd0);
        run_random(100);
        write_mode_count(2'd3);
        run_random(100);

        // Decisions are held off while events keep coming, so the block
        // fills up and stops taking restart transfers.
        long_hold_req = 1'b1;
        run_random(12);

        // The count never grows here, which drives the stall counter into
        // saturation.
        for (k = 0; k < 280; k++)
            send_random_event(1'b1);
        run_random(50);

        write_mode_count(2'd2);
        steady = 1'b1;
        run_random(100);
        steady = 1'b0;
        run_random(450);

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
sv/sbms_pkg.sv
sv/sbms_if.sv
sv/sbms_divider.sv
sv/softmax_bandit_mode_select.sv
dv/sbms_decision_checker.sv
dv/softmax_bandit_mode_select_test.sv
